// File: hdl/sha256_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hash package
// Shared types, codes and constants for the SHA-256 stream hash core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sha256_pkg;

  typedef logic [7:0][31:0]  work_t;
  typedef logic [15:0][31:0] sched_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_req_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_OUT
  } state_e;

  localparam logic [7:0] PadByte   = 8'h80;
  localparam logic [5:0] LenPos    = 6'd56;
  localparam logic [5:0] LastPos   = 6'd63;
  localparam logic [5:0] LastRound = 6'd63;
  localparam logic [2:0] LastWord  = 3'd7;

  localparam work_t HashInit = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0:  k = 32'h428a2f98;
      6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;
      6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;
      6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;
      6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;
      6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;
      6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;
      6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;
      6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;
      6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;
      6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;
      6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;
      6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;
      6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;
      6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;
      6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;
      6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;
      6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;
      6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;
      6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;
      6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;
      6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;
      6'd63: k = 32'hc67178f2;
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// File: hdl/sha256_round.sv
// ----------------------------------------------------------------------------
// SHA-256 round unit
// One compression round and one message schedule step, shared by all rounds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sha256_round (
  input  sha256_pkg::work_t  work_i,
  input  sha256_pkg::sched_t sched_i,
  input  logic [31:0]        k_i,
  output sha256_pkg::work_t  work_o,
  output sha256_pkg::sched_t sched_o
);
  import sha256_pkg::*;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  logic [31:0] a, b, c, d, e, f, g, h;
  logic [31:0] w_cur, w_new, s0, s1, big_s0, big_s1, ch, maj, t1, t2;

  assign {h, g, f, e, d, c, b, a} = work_i;

  // The oldest schedule word sits at the top; new words enter at the bottom.
  assign w_cur = sched_i[15];
  assign s0    = rotr(sched_i[14], 7) ^ rotr(sched_i[14], 18) ^ (sched_i[14] >> 3);
  assign s1    = rotr(sched_i[1], 17) ^ rotr(sched_i[1], 19) ^ (sched_i[1] >> 10);
  assign w_new = s1 + sched_i[6] + s0 + w_cur;

  assign big_s1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
  assign big_s0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
  assign ch     = (e & f) ^ (~e & g);
  assign maj    = (a & b) ^ (a & c) ^ (b & c);
  assign t1     = h + big_s1 + ch + k_i + w_cur;
  assign t2     = big_s0 + maj;

  assign work_o  = {g, f, e, d + t1, c, b, a, t1 + t2};
  assign sched_o = {sched_i[14:0], w_new};

endmodule

`default_nettype wire

// File: hdl/sha256_stream_hash_core.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hash core
// Packs message bytes into a block, runs the 64 rounds on a shared round
// unit, pads the message at its end and returns the digest word by word.
// ----------------------------------------------------------------------------
// Each request with a byte is taken while the core is idle; the 64th byte of a
// block starts 64 rounds on the single round unit, with the input stalled.
// A closing request inserts padding one byte per cycle (one or two padded
// blocks), runs 64 rounds per padded block, then offers eight words.
// Reset loads the initial hash values and clears the byte count; no clearing
// pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module sha256_stream_hash_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  sha256_pkg::in_req_t  in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output sha256_pkg::out_req_t out_req_o
);
  import sha256_pkg::*;

  state_e      state_q, state_d;
  logic [5:0]  pos_q, pos_d;
  logic [5:0]  round_q, round_d;
  logic [60:0] count_q, count_d;
  logic [2:0]  out_idx_q, out_idx_d;
  logic        pad_q, pad_d, first_q, first_d, final_q, final_d, done_q, done_d;
  work_t       hash_q, hash_d, work_q, work_d, rnd_work;
  sched_t      w_q, w_d, rnd_sched;

  logic        ins_en;
  logic [7:0]  ins_byte, pad_byte, len_byte;
  logic [63:0] len_bits, len_shift;
  logic        msg_take;

  sha256_round u_round (
    .work_i  (work_q),
    .sched_i (w_q),
    .k_i     (round_k(round_q)),
    .work_o  (rnd_work),
    .sched_o (rnd_sched)
  );

  assign msg_take  = (state_q == ST_IDLE) && in_valid_i;
  assign len_bits  = {count_q, 3'b000};
  assign len_shift = len_bits >> {~pos_q[2:0], 3'b000};
  assign len_byte  = len_shift[7:0];

  always_comb begin
    if (first_q) begin
      pad_byte = PadByte;
    end else if (final_q && (pos_q >= LenPos)) begin
      pad_byte = len_byte;
    end else begin
      pad_byte = '0;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_req_i.byte_present && (pos_q == LastPos)) begin
            state_d = ST_COMP;
          end else if (in_req_i.end_of_message) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (pos_q == LastPos) begin
          state_d = ST_COMP;
        end
      end
      ST_COMP: begin
        if (round_q == LastRound) begin
          if (done_q) begin
            state_d = ST_OUT;
          end else if (pad_q) begin
            state_d = ST_PAD;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_OUT: begin
        if (!out_stall_i && (out_idx_q == LastWord)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    ins_en      = 1'b0;
    ins_byte    = in_req_i.data_byte;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        ins_en     = in_valid_i && in_req_i.byte_present;
      end
      ST_PAD: begin
        ins_en   = 1'b1;
        ins_byte = pad_byte;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
      end
      default: begin
        ins_en = 1'b0;
      end
    endcase
  end

  assign out_req_o.digest_word = hash_q[out_idx_q];
  assign out_req_o.word_index  = out_idx_q;
  assign out_req_o.last_word   = (out_idx_q == LastWord);

  always_comb begin
    pos_d     = pos_q;
    round_d   = round_q;
    count_d   = count_q;
    out_idx_d = out_idx_q;
    pad_d     = pad_q;
    first_d   = first_q;
    final_d   = final_q;
    done_d    = done_q;
    hash_d    = hash_q;
    work_d    = work_q;
    w_d       = w_q;

    if (ins_en) begin
      w_d   = sched_t'({w_q, ins_byte});
      pos_d = pos_q + 6'd1;
    end

    if (msg_take && in_req_i.byte_present) begin
      count_d = count_q + 61'd1;
    end
    if (msg_take && in_req_i.end_of_message) begin
      pad_d   = 1'b1;
      first_d = 1'b1;
      final_d = 1'b0;
      done_d  = 1'b0;
    end

    // The length goes into the block where the marker byte leaves room for it.
    if (state_q == ST_PAD) begin
      first_d = 1'b0;
      if (first_q) begin
        final_d = (pos_q < LenPos) || (pos_q == LastPos);
      end else if (pos_q == LastPos) begin
        if (final_q) begin
          done_d = 1'b1;
        end else begin
          final_d = 1'b1;
        end
      end
    end

    if ((state_q != ST_COMP) && (state_d == ST_COMP)) begin
      work_d = hash_q;
    end

    if (state_q == ST_COMP) begin
      work_d  = rnd_work;
      w_d     = rnd_sched;
      round_d = round_q + 6'd1;
      if (round_q == LastRound) begin
        for (int i = 0; i < 8; i++) begin
          hash_d[i] = hash_q[i] + rnd_work[i];
        end
        if (done_q) begin
          pad_d   = 1'b0;
          final_d = 1'b0;
          done_d  = 1'b0;
        end
      end
    end

    if ((state_q == ST_OUT) && !out_stall_i) begin
      out_idx_d = out_idx_q + 3'd1;
      if (out_idx_q == LastWord) begin
        hash_d  = HashInit;
        count_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pos_q     <= '0;
      round_q   <= '0;
      count_q   <= '0;
      out_idx_q <= '0;
      pad_q     <= 1'b0;
      first_q   <= 1'b0;
      final_q   <= 1'b0;
      done_q    <= 1'b0;
      hash_q    <= HashInit;
    end else begin
      state_q   <= state_d;
      pos_q     <= pos_d;
      round_q   <= round_d;
      count_q   <= count_d;
      out_idx_q <= out_idx_d;
      pad_q     <= pad_d;
      first_q   <= first_d;
      final_q   <= final_d;
      done_q    <= done_d;
      hash_q    <= hash_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    w_q    <= w_d;
  end

  a_block_starts_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q != ST_COMP) && (state_d == ST_COMP)) |=> (pos_q == '0))
    else $error("Compression started on a partial block.");

  a_round_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_COMP) |-> (round_q == '0))
    else $error("Round counter moved outside compression.");

  a_done_needs_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (final_q && pad_q))
    else $error("Padding finished without the length block.");

  a_digest_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && out_req_o.last_word) |=>
      ((state_q == ST_IDLE) && (count_q == '0) && (hash_q == HashInit)))
    else $error("Hash state not restored after the digest.");

endmodule

`default_nettype wire
